[rtl/swtt_pkg.sv]
// ----------------------------------------------------------------------------
// swtt_pkg
// Shared types and constants for the software timer table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swtt_pkg;

  // Most results one tick request may produce
  localparam int unsigned MAX_RESULTS = 16;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TICK   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    KIND_ADDED   = 3'd0,
    KIND_REMOVED = 3'd1,
    KIND_FIRED   = 3'd2,
    KIND_NONE    = 3'd3,
    KIND_FULL    = 3'd4
  } kind_e;

  // One slot as stored in the slot RAM
  typedef struct packed {
    logic [31:0] period;
    logic [63:0] last_call;
    logic        repeat_mode;
  } slot_entry_t;

endpackage

`default_nettype wire

[rtl/swtt_if.sv]
// ----------------------------------------------------------------------------
// swtt_req_if / swtt_rsp_if
// Valid/ready channels for timer requests and timer results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swtt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] now;
  logic [31:0] period;
  logic        repeat_mode;
  logic [3:0]  slot_sel;

  modport source (output valid, req_type, now, period, repeat_mode, slot_sel,
                  input ready);
  modport sink   (input valid, req_type, now, period, repeat_mode, slot_sel,
                  output ready);
endinterface

interface swtt_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [3:0] slot_id;
  logic       last;

  modport source (output valid, result_kind, slot_id, last, input ready);
  modport sink   (input valid, result_kind, slot_id, last, output ready);
endinterface

`default_nettype wire

[rtl/swtt_ram.sv]
// ----------------------------------------------------------------------------
// swtt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/software_timer_table.sv]
// ----------------------------------------------------------------------------
// software_timer_table
// Table of periodic and one-shot timer slots evaluated against a counter.
// ----------------------------------------------------------------------------
// Requests: a remove goes from the accepting state straight to emit; an add
//   probes slots in turn for a free entry, then emits; a tick walks the slots
//   in turn (RAM read, then the shared 65-bit add and compare), then emits.
// Throughput: one request at a time, plus any result-side stall cycles; a
//   finished result may wait in the output register while the next is taken.
// Reset: all slots marked free at once; slot RAM contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module software_timer_table
  import swtt_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  swtt_req_if.sink    req_i,
  swtt_rsp_if.source  rsp_o
);

  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned EW   = $bits(slot_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_TICK_RD,
    ST_TICK_EV,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [SLOTS-1:0] valid_q;      // per-slot busy flags, cleared by reset
  logic [IW-1:0]   idx_q;         // slot walker, shared by add and tick
  logic [CW-1:0]   cnt_q;         // fired results of the current tick

  // latched request payload
  logic [63:0]     now_q;
  logic [31:0]     period_q;
  logic            rep_q;

  // held result: a fired slot is held back until we know whether it is final
  logic            pend_valid_q;
  kind_e           pend_kind_q;
  logic [3:0]      pend_slot_q;

  // output register
  logic            out_valid_q;
  kind_e           out_kind_q;
  logic [3:0]      out_slot_q;
  logic            out_last_q;

  // slot RAM
  logic            ram_we;
  logic            ram_re;
  slot_entry_t     ram_wdata;
  logic [EW-1:0]   ram_rdata;
  slot_entry_t     rd_entry;

  logic            accept;
  logic            out_free;
  logic            out_load;
  logic            idx_end;
  logic [IW-1:0]   sel_idx;
  logic            sel_ok;
  logic [64:0]     deadline;
  logic            due;
  logic            fire_go;
  logic            add_hit;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign idx_end  = (idx_q == IW'(SLOTS - 1));
  assign sel_idx  = IW'(req_i.slot_sel);
  assign sel_ok   = (32'(req_i.slot_sel) < 32'(SLOTS));
  assign rd_entry = slot_entry_t'(ram_rdata);

  // Shared evaluation unit: deadline formed exactly in 65 bits so a carry
  // out can never look due.
  assign deadline = {1'b0, rd_entry.last_call} + {33'b0, rd_entry.period};
  assign due      = valid_q[idx_q] && (deadline <= {1'b0, now_q});

  // A due slot proceeds once any held result can move to the output register
  assign fire_go  = (state_q == ST_TICK_EV) && due && (!pend_valid_q || out_free);
  assign add_hit  = (state_q == ST_ADD_SCAN) && !valid_q[idx_q];

  // output register takes a new transaction this cycle
  assign out_load = (fire_go && pend_valid_q) || ((state_q == ST_EMIT) && out_free);

  always_comb begin
    ram_re    = (state_q == ST_TICK_RD);
    ram_we    = add_hit || (fire_go && rd_entry.repeat_mode);
    ram_wdata = '0;
    if (state_q == ST_ADD_SCAN) begin
      ram_wdata.period      = period_q;
      ram_wdata.last_call   = now_q;
      ram_wdata.repeat_mode = rep_q;
    end else begin
      // repeating slot restarts from the current counter
      ram_wdata.period      = rd_entry.period;
      ram_wdata.last_call   = now_q;
      ram_wdata.repeat_mode = 1'b1;
    end
  end

  swtt_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
      cnt_q        <= '0;
    end else begin
      // output register drains when the sink takes the transaction
      if (out_valid_q && rsp_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            now_q    <= req_i.now;
            period_q <= req_i.period;
            rep_q    <= req_i.repeat_mode;
            idx_q    <= '0;
            cnt_q    <= '0;
            unique case (req_i.req_type)
              REQ_ADD: begin
                state_q <= ST_ADD_SCAN;
              end
              REQ_REMOVE: begin
                // out-of-range slot is reported but touches nothing
                if (sel_ok) begin
                  valid_q[sel_idx] <= 1'b0;
                end
                pend_valid_q <= 1'b1;
                pend_kind_q  <= KIND_REMOVED;
                pend_slot_q  <= req_i.slot_sel;
                state_q      <= ST_EMIT;
              end
              REQ_TICK: begin
                pend_valid_q <= 1'b0;
                state_q      <= ST_TICK_RD;
              end
              default: begin
                // undefined request code: dropped silently
                state_q <= ST_IDLE;
              end
            endcase
          end
        end

        ST_ADD_SCAN: begin
          if (add_hit) begin
            valid_q[idx_q] <= 1'b1;
            pend_valid_q   <= 1'b1;
            pend_kind_q    <= KIND_ADDED;
            pend_slot_q    <= 4'(idx_q);
            state_q        <= ST_EMIT;
          end else if (idx_end) begin
            pend_valid_q <= 1'b1;
            pend_kind_q  <= KIND_FULL;
            pend_slot_q  <= '0;
            state_q      <= ST_EMIT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end

        ST_TICK_RD: begin
          state_q <= ST_TICK_EV;
        end

        ST_TICK_EV: begin
          if (!due) begin
            if (idx_end) begin
              state_q <= ST_EMIT;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_TICK_RD;
            end
          end else if (fire_go) begin
            // earlier fired slot is not the final one
            if (pend_valid_q) begin
              out_valid_q <= 1'b1;
              out_kind_q  <= pend_kind_q;
              out_slot_q  <= pend_slot_q;
              out_last_q  <= 1'b0;
            end
            pend_valid_q <= 1'b1;
            pend_kind_q  <= KIND_FIRED;
            pend_slot_q  <= 4'(idx_q);
            cnt_q        <= cnt_q + 1'b1;
            if (!rd_entry.repeat_mode) begin
              valid_q[idx_q] <= 1'b0;
            end
            // stop at the result cap; remaining due slots wait for a later tick
            if (idx_end || (cnt_q == CW'(MAX_RESULTS - 1))) begin
              state_q <= ST_EMIT;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_TICK_RD;
            end
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_last_q   <= 1'b1;
            pend_valid_q <= 1'b0;
            if (pend_valid_q) begin
              out_kind_q <= pend_kind_q;
              out_slot_q <= pend_slot_q;
            end else begin
              // tick with nothing due
              out_kind_q <= KIND_NONE;
              out_slot_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_kind = out_kind_q;
  assign rsp_o.slot_id     = out_slot_q;
  assign rsp_o.last        = out_last_q;

endmodule

`default_nettype wire
